### rtl/rbdc_pkg.sv
// Package for the RTC BCD date/time codec: field widths, the opcode type,
// the beat and time-field structs and the BCD pack/unpack helpers.
// Used by every other file of the block; depends on nothing.
package rbdc_pkg;

    localparam int IMAGE_W   = 56;
    localparam int SEC_W     = 6;
    localparam int MIN_W     = 6;
    localparam int HOUR_W    = 5;
    localparam int WDAY_W    = 3;
    localparam int DAY_W     = 5;
    localparam int MONTH_W   = 4;
    localparam int YEAR_W    = 12;

    localparam logic [7:0] MASK_SEC_MIN = 8'h7f;
    localparam logic [7:0] MASK_HOUR    = 8'h3f;
    localparam logic [7:0] MASK_DAY     = 8'h3f;
    localparam logic [7:0] MASK_MONTH   = 8'h1f;
    localparam logic [7:0] CENTURY_BIT  = 8'h80;

    localparam logic [YEAR_W-1:0] YEAR_BASE      = 12'd2000;
    localparam logic [YEAR_W-1:0] YEAR_PREV_BASE = 12'd1900;
    localparam logic [YEAR_W-1:0] YEAR_NEXT_BASE = 12'd2100;
    localparam logic [YEAR_W-1:0] CENTURY_SPAN   = 12'd100;
    localparam logic [7:0]        YEAR_WRAP_OFF  = 8'd70;

    typedef enum logic {
        OP_DECODE = 1'b0,
        OP_ENCODE = 1'b1
    } t_opcode;

    typedef struct packed {
        logic [SEC_W-1:0]   seconds;
        logic [MIN_W-1:0]   minutes;
        logic [HOUR_W-1:0]  hours;
        logic [WDAY_W-1:0]  weekday;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } t_time;

    typedef struct packed {
        t_opcode              opcode;
        logic [IMAGE_W-1:0]   image;
        t_time                fields;
    } t_in_beat;

    typedef struct packed {
        logic [IMAGE_W-1:0]   image;
        t_time                fields;
    } t_out_beat;

    // Two BCD digits to binary; digits above nine keep their weight.
    function automatic logic [7:0] bcd_unpack(input logic [7:0] b);
        logic [7:0] hi;
        hi = {4'b0, b[7:4]};
        return {4'b0, b[3:0]} + (hi << 3) + (hi << 1);
    endfunction

    // Binary byte to two BCD digits; tens come from a multiply by 205/2048,
    // exact over 0..255. Tens above nine keep only their low nibble.
    function automatic logic [7:0] bcd_pack(input logic [7:0] v);
        logic [15:0] prod;
        logic [4:0]  tens;
        logic [7:0]  units;
        prod  = {8'b0, v} * 16'd205;
        tens  = prod[15:11];
        units = v - ({3'b0, tens} << 3) - ({3'b0, tens} << 1);
        return {tens[3:0], units[3:0]};
    endfunction

endpackage

### rtl/rbdc_if.sv
// Valid/ready channel interfaces for the input and result beats of the codec.
// Depends on rbdc_pkg.
interface rbdc_in_if;
    import rbdc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 opcode;
    logic [IMAGE_W-1:0]   register_image;
    logic [SEC_W-1:0]     seconds_in;
    logic [MIN_W-1:0]     minutes_in;
    logic [HOUR_W-1:0]    hours_in;
    logic [WDAY_W-1:0]    weekday_in;
    logic [DAY_W-1:0]     day_in;
    logic [MONTH_W-1:0]   month_in;
    logic [YEAR_W-1:0]    year_in;

    modport source (
        output valid, opcode, register_image, seconds_in, minutes_in, hours_in,
               weekday_in, day_in, month_in, year_in,
        input  ready
    );
    modport sink (
        input  valid, opcode, register_image, seconds_in, minutes_in, hours_in,
               weekday_in, day_in, month_in, year_in,
        output ready
    );
endinterface

interface rbdc_out_if;
    import rbdc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [IMAGE_W-1:0]   image_out;
    logic [SEC_W-1:0]     seconds_out;
    logic [MIN_W-1:0]     minutes_out;
    logic [HOUR_W-1:0]    hours_out;
    logic [WDAY_W-1:0]    weekday_out;
    logic [DAY_W-1:0]     day_out;
    logic [MONTH_W-1:0]   month_out;
    logic [YEAR_W-1:0]    year_out;

    modport source (
        output valid, image_out, seconds_out, minutes_out, hours_out,
               weekday_out, day_out, month_out, year_out,
        input  ready
    );
    modport sink (
        input  valid, image_out, seconds_out, minutes_out, hours_out,
               weekday_out, day_out, month_out, year_out,
        output ready
    );
endinterface

### rtl/rtc_bcd_datetime_codec_top.sv
// RTC BCD date/time codec. Each input beat either decodes a seven-byte clock
// register image (byte 0 seconds up to byte 6 year, century flag in bit 7 of
// the month byte) into clamped binary fields, or encodes binary fields into
// such an image in 24-hour mode; every beat gives exactly one result beat.
// The block is a two-register pipeline: an input register, one level of
// BCD pack/unpack and clamp logic, and a result register. It takes one beat
// per clock cycle while no stall holds the output. An accepted beat is held
// first in the input register and then in the result register, which offers
// its result on the output. Each register stage advances
// whenever the next one is empty or being emptied, so a result waiting on
// the output does not stop the input until both stages are full. In a
// decode result image_out is zero; in an encode result all time fields are.
// Depends on rbdc_pkg, rbdc_if, rbdc_decode and rbdc_encode.
module rtc_bcd_datetime_codec_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rbdc_in_if.sink        i_in,
    rbdc_out_if.source     o_out
);
    import rbdc_pkg::*;

    // Input register stage.
    logic      r_s1_valid, n_s1_valid;
    t_in_beat  r_s1;
    logic      s1_ready;

    // Result register stage.
    logic      r_out_valid, n_out_valid;
    t_out_beat r_out, n_out;
    logic      out_ready;

    t_time             dec_time;
    logic [IMAGE_W-1:0] enc_image;
    t_time             s1_time;

    // A stage can load when it is empty or its content moves on this cycle.
    assign out_ready = !r_out_valid || o_out.ready;
    assign s1_ready  = !r_s1_valid || out_ready;
    assign i_in.ready = s1_ready;

    assign n_s1_valid  = s1_ready ? i_in.valid : r_s1_valid;
    assign n_out_valid = out_ready ? r_s1_valid : r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers load only on an accepted beat or stage advance.
    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in.valid) begin
            r_s1.opcode         <= t_opcode'(i_in.opcode);
            r_s1.image          <= i_in.register_image;
            r_s1.fields.seconds <= i_in.seconds_in;
            r_s1.fields.minutes <= i_in.minutes_in;
            r_s1.fields.hours   <= i_in.hours_in;
            r_s1.fields.weekday <= i_in.weekday_in;
            r_s1.fields.day     <= i_in.day_in;
            r_s1.fields.month   <= i_in.month_in;
            r_s1.fields.year    <= i_in.year_in;
        end
        if (out_ready && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign s1_time = r_s1.fields;

    rbdc_decode u_decode (
        .i_image (r_s1.image),
        .o_time  (dec_time)
    );

    rbdc_encode u_encode (
        .i_time  (s1_time),
        .o_image (enc_image)
    );

    // Only the fields of the selected direction are passed; the others are zero.
    always_comb begin
        case (r_s1.opcode)
            OP_DECODE: begin
                n_out.image  = '0;
                n_out.fields = dec_time;
            end
            OP_ENCODE: begin
                n_out.image  = enc_image;
                n_out.fields = '0;
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.image_out   = r_out.image;
    assign o_out.seconds_out = r_out.fields.seconds;
    assign o_out.minutes_out = r_out.fields.minutes;
    assign o_out.hours_out   = r_out.fields.hours;
    assign o_out.weekday_out = r_out.fields.weekday;
    assign o_out.day_out     = r_out.fields.day;
    assign o_out.month_out   = r_out.fields.month;
    assign o_out.year_out    = r_out.fields.year;

`ifndef SYNTHESIS
    // A result carries either an image or time fields, never both.
    a_one_direction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.image_out == '0) ||
            (o_out.seconds_out == '0 && o_out.minutes_out == '0 &&
             o_out.hours_out == '0 && o_out.weekday_out == '0 &&
             o_out.day_out == '0 && o_out.month_out == '0 && o_out.year_out == '0))
        else $error("result mixes encode and decode fields");

    // A decode result (month never zero) stays within the clamped ranges.
    a_decode_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.month_out != '0) |->
            (o_out.seconds_out <= 6'd59 && o_out.minutes_out <= 6'd59 &&
             o_out.hours_out <= 5'd23 && o_out.weekday_out <= 3'd6 &&
             o_out.day_out != '0 && o_out.month_out <= 4'd12 &&
             o_out.year_out >= 12'd1970 && o_out.year_out <= 12'd2169))
        else $error("decoded field out of range");

    // A beat in the input stage moves to the result stage when that can load.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && out_ready) |=> r_out_valid)
        else $error("input stage beat lost");

    // An empty input stage always takes a new beat.
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> i_in.ready)
        else $error("input stalled with empty input stage");
`endif

endmodule

### rtl/rbdc_decode.sv
// Decode path: masks and unpacks the seven register bytes into clamped
// binary date and time fields. Purely combinational; depends on rbdc_pkg.
module rbdc_decode (
    input  logic [rbdc_pkg::IMAGE_W-1:0] i_image,
    output rbdc_pkg::t_time              o_time
);
    import rbdc_pkg::*;

    logic [7:0] b_sec, b_min, b_hour, b_wday, b_day, b_mon, b_year;
    logic [7:0] v_sec, v_min, v_hour, v_day, v_mon, v_year;
    logic [YEAR_W-1:0] year_raw;

    assign b_sec  = i_image[7:0];
    assign b_min  = i_image[15:8];
    assign b_hour = i_image[23:16];
    assign b_wday = i_image[31:24];
    assign b_day  = i_image[39:32];
    assign b_mon  = i_image[47:40];
    assign b_year = i_image[55:48];

    assign v_sec  = bcd_unpack(b_sec & MASK_SEC_MIN);
    assign v_min  = bcd_unpack(b_min & MASK_SEC_MIN);
    assign v_hour = bcd_unpack(b_hour & MASK_HOUR);
    assign v_day  = bcd_unpack(b_day & MASK_DAY);
    assign v_mon  = bcd_unpack(b_mon & MASK_MONTH);
    assign v_year = bcd_unpack(b_year);

    assign year_raw = YEAR_BASE + {4'b0, v_year};

    always_comb begin
        o_time.seconds = (v_sec > 8'd59) ? SEC_W'(59) : v_sec[SEC_W-1:0];
        o_time.minutes = (v_min > 8'd59) ? MIN_W'(59) : v_min[MIN_W-1:0];
        o_time.hours   = (v_hour > 8'd23) ? HOUR_W'(23) : v_hour[HOUR_W-1:0];
        // A raw weekday of zero counts as one before going zero-based.
        o_time.weekday = (b_wday[2:0] == 3'd0) ? WDAY_W'(0) : b_wday[2:0] - 3'd1;
        if (v_day == 8'd0) begin
            o_time.day = DAY_W'(1);
        end else if (v_day > 8'd31) begin
            o_time.day = DAY_W'(31);
        end else begin
            o_time.day = v_day[DAY_W-1:0];
        end
        if (v_mon == 8'd0) begin
            o_time.month = MONTH_W'(1);
        end else if (v_mon > 8'd12) begin
            o_time.month = MONTH_W'(12);
        end else begin
            o_time.month = v_mon[MONTH_W-1:0];
        end
        // With the century flag set, values of 70 and up mean the previous century
        // and smaller values the next one.
        if ((b_mon & CENTURY_BIT) != 8'd0) begin
            if (v_year >= YEAR_WRAP_OFF) begin
                o_time.year = year_raw - CENTURY_SPAN;
            end else begin
                o_time.year = year_raw + CENTURY_SPAN;
            end
        end else begin
            o_time.year = year_raw;
        end
    end

endmodule

### rtl/rbdc_encode.sv
// Encode path: packs binary date and time fields into the seven-byte BCD
// register image, 24-hour mode. Purely combinational; depends on rbdc_pkg.
module rbdc_encode (
    input  rbdc_pkg::t_time              i_time,
    output logic [rbdc_pkg::IMAGE_W-1:0] o_image
);
    import rbdc_pkg::*;

    logic              century;
    logic [YEAR_W-1:0] year_off;
    logic [7:0]        b_wday;
    logic [7:0]        b_mon;

    // The century flag marks years before 2000 and from 2100 on; the offset
    // is taken from the matching base and wraps to one byte.
    always_comb begin
        if (i_time.year < YEAR_BASE) begin
            century  = 1'b1;
            year_off = i_time.year - YEAR_PREV_BASE;
        end else if (i_time.year >= YEAR_NEXT_BASE) begin
            century  = 1'b1;
            year_off = i_time.year - YEAR_NEXT_BASE;
        end else begin
            century  = 1'b0;
            year_off = i_time.year - YEAR_BASE;
        end
    end

    assign b_wday = {5'b0, i_time.weekday} + 8'd1;
    assign b_mon  = bcd_pack({4'b0, i_time.month}) | (century ? CENTURY_BIT : 8'h00);

    assign o_image = {bcd_pack(year_off[7:0]),
                      b_mon,
                      bcd_pack({3'b0, i_time.day}),
                      b_wday,
                      bcd_pack({3'b0, i_time.hours}),
                      bcd_pack({2'b0, i_time.minutes}),
                      bcd_pack({2'b0, i_time.seconds})};

endmodule

### dv/tb_datetime_scoreboard_pkg.sv
// Scoreboard for the RTC BCD date/time codec: predicts each conversion and checks result beats.
// Depends on rbdc_pkg for the beat structs, the field widths and the opcode type.
package tb_datetime_scoreboard_pkg;
    import rbdc_pkg::*;

    localparam int unsigned REPORT_LIMIT = 10;

    class datetime_scoreboard;
        t_out_beat   pending_conversions[$];
        int unsigned mismatch_count;
        int unsigned results_seen;

        function new();
            mismatch_count = 0;
            results_seen = 0;
        endfunction

        // Two BCD digits to binary. A nibble above nine keeps its weight.
        static function int unsigned bcd_value(logic [7:0] b);
            int unsigned lo;
            int unsigned hi;
            lo = b[3:0];
            hi = b[7:4];
            return lo + hi * 10;
        endfunction

        // Low byte of v split into tens and units. Tens above nine keep only their low nibble.
        static function logic [7:0] bcd_byte(int unsigned v);
            int unsigned tens;
            int unsigned units;
            tens  = (v & 'hff) / 10;
            units = (v & 'hff) - tens * 10;
            return 8'(((tens << 4) | units) & 'hff);
        endfunction

        static function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function t_out_beat convert_datetime(t_in_beat b);
            t_out_beat   r;
            int unsigned yr;
            logic [7:0]  month_byte;
            r = '0;
            if (b.opcode == OP_DECODE) begin
                r.fields.seconds = SEC_W'(clamp(bcd_value(b.image[7:0] & 8'h7f), 0, 59));
                r.fields.minutes = MIN_W'(clamp(bcd_value(b.image[15:8] & 8'h7f), 0, 59));
                r.fields.hours   = HOUR_W'(clamp(bcd_value(b.image[23:16] & 8'h3f), 0, 23));
                r.fields.weekday = WDAY_W'(clamp(b.image[26:24], 1, 7) - 1);
                r.fields.day     = DAY_W'(clamp(bcd_value(b.image[39:32] & 8'h3f), 1, 31));
                r.fields.month   = MONTH_W'(clamp(bcd_value(b.image[47:40] & 8'h1f), 1, 12));
                // The century flag moves years 2070 and up back by a century (2070..2099
                // to the 1900s) and pushes the rest forward into the 2100s.
                yr = bcd_value(b.image[55:48]) + 2000;
                if (b.image[47]) begin
                    yr = (yr >= 2070) ? yr - 100 : yr + 100;
                end
                r.fields.year = YEAR_W'(yr);
            end else begin
                yr = b.fields.year;
                month_byte = bcd_byte(b.fields.month);
                if (yr < 2000) begin
                    month_byte[7] = 1'b1;
                    yr = yr + 100;
                end else if (yr >= 2100) begin
                    month_byte[7] = 1'b1;
                    yr = yr - 100;
                end
                r.image = {bcd_byte((yr - 2000) & 'hff), month_byte,
                           bcd_byte(b.fields.day), 8'(b.fields.weekday + 1),
                           bcd_byte(b.fields.hours), bcd_byte(b.fields.minutes),
                           bcd_byte(b.fields.seconds)};
            end
            return r;
        endfunction

        function void note_input(t_in_beat b);
            pending_conversions.push_back(convert_datetime(b));
        endfunction

        function void flag_failure(string msg);
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("[%0t] result %0d: %s", $time, results_seen, msg);
            end
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                flag_failure($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
            end
        endfunction

        function void check_result(t_out_beat got);
            t_out_beat want;
            if (pending_conversions.size() == 0) begin
                flag_failure($sformatf("unexpected result beat, image_out 0x%0h", got.image));
            end else begin
                want = pending_conversions.pop_front();
                compare_field("image_out", want.image, got.image);
                compare_field("seconds_out", want.fields.seconds, got.fields.seconds);
                compare_field("minutes_out", want.fields.minutes, got.fields.minutes);
                compare_field("hours_out", want.fields.hours, got.fields.hours);
                compare_field("weekday_out", want.fields.weekday, got.fields.weekday);
                compare_field("day_out", want.fields.day, got.fields.day);
                compare_field("month_out", want.fields.month, got.fields.month);
                compare_field("year_out", want.fields.year, got.fields.year);
            end
            results_seen++;
        endfunction

        function int unsigned waiting();
            return pending_conversions.size();
        endfunction

        function int unsigned failures();
            return mismatch_count;
        endfunction
    endclass

endpackage

### dv/tb_top.sv
// Top-level testbench for the RTC BCD date/time codec: directed and random decode/encode beats
// with random stalls on both channels, checked against the scoreboard's prediction.
// Depends on rbdc_pkg, rbdc_if, tb_datetime_scoreboard_pkg and the codec RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rbdc_pkg::*;
    import tb_datetime_scoreboard_pkg::*;

    localparam int unsigned RANDOM_BEATS = 1300;
    // The last beats of the run go out with no idling on either side.
    localparam int unsigned QUIET_TAIL   = 150;
    // After 600 random beats, the sender stops until every result is back.
    localparam int unsigned DRAIN_POINT  = 600;
    // Cycles with no beat on either channel before the run is declared hung.
    localparam int unsigned STALL_LIMIT  = 2000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    rbdc_in_if  in_ch();
    rbdc_out_if out_ch();

    rtc_bcd_datetime_codec_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    datetime_scoreboard sb = new();

    // Idling is switched on and off in stretches so that runs without any
    // gaps alternate with runs full of bursts.
    bit          idle_enabled = 1'b0;
    bit          quiet_tail   = 1'b0;
    int unsigned stall_run    = 0;
    int unsigned idle_cycles  = 0;

    // Result-side stalls: ready drops in bursts, and ready goes high again after
    // every burst. All changes happen on the falling edge, away from the sampling
    // edge.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_run != 0) begin
                out_ch.ready = 1'b0;
                stall_run--;
            end else if (!out_ch.ready) begin
                out_ch.ready = 1'b1;
            end else if (idle_enabled && !quiet_tail && $urandom_range(0, 7) == 0) begin
                stall_run = $urandom_range(1, 16) - 1;
                out_ch.ready = 1'b0;
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    // Both channels are sampled at the rising edge. A beat accepted on the
    // input side goes to the predictor, a result beat goes to the checker.
    // The same block runs the hang watchdog.
    always @(posedge i_clk) begin
        t_in_beat  seen_in;
        t_out_beat seen_out;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                seen_in.opcode         = t_opcode'(in_ch.opcode);
                seen_in.image          = in_ch.register_image;
                seen_in.fields.seconds = in_ch.seconds_in;
                seen_in.fields.minutes = in_ch.minutes_in;
                seen_in.fields.hours   = in_ch.hours_in;
                seen_in.fields.weekday = in_ch.weekday_in;
                seen_in.fields.day     = in_ch.day_in;
                seen_in.fields.month   = in_ch.month_in;
                seen_in.fields.year    = in_ch.year_in;
                sb.note_input(seen_in);
            end
            if (out_ch.valid && out_ch.ready) begin
                seen_out.image          = out_ch.image_out;
                seen_out.fields.seconds = out_ch.seconds_out;
                seen_out.fields.minutes = out_ch.minutes_out;
                seen_out.fields.hours   = out_ch.hours_out;
                seen_out.fields.weekday = out_ch.weekday_out;
                seen_out.fields.day     = out_ch.day_out;
                seen_out.fields.month   = out_ch.month_out;
                seen_out.fields.year    = out_ch.year_out;
                sb.check_result(seen_out);
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT) begin
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    // A beat full of random bits; the callers overwrite what they care about,
    // so the unused part of every beat still carries noise.
    function automatic t_in_beat noisy_beat();
        logic [127:0] r;
        r = {$urandom, $urandom, $urandom, $urandom};
        return r[$bits(t_in_beat)-1:0];
    endfunction

    function automatic t_in_beat decode_beat(logic [IMAGE_W-1:0] img);
        t_in_beat b;
        b = noisy_beat();
        b.opcode = OP_DECODE;
        b.image  = img;
        return b;
    endfunction

    function automatic t_in_beat encode_beat(int unsigned sec, int unsigned mins,
                                             int unsigned hrs, int unsigned wday,
                                             int unsigned mday, int unsigned mon,
                                             int unsigned yr);
        t_in_beat b;
        b = noisy_beat();
        b.opcode         = OP_ENCODE;
        b.fields.seconds = SEC_W'(sec);
        b.fields.minutes = MIN_W'(mins);
        b.fields.hours   = HOUR_W'(hrs);
        b.fields.weekday = WDAY_W'(wday);
        b.fields.day     = DAY_W'(mday);
        b.fields.month   = MONTH_W'(mon);
        b.fields.year    = YEAR_W'(yr);
        return b;
    endfunction

    // A random value in lo..hi as two clean BCD digits.
    function automatic logic [7:0] clean_bcd(int unsigned lo, int unsigned hi);
        int unsigned v;
        v = $urandom_range(lo, hi);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    // Most random beats are plausible clock images or in-range dates, since
    // those exercise the century logic; the rest is raw noise and field
    // values beyond the calendar.
    function automatic t_in_beat random_beat();
        logic [7:0] month_byte;
        case ($urandom_range(0, 9))
            0, 1: return decode_beat(IMAGE_W'({$urandom, $urandom}));
            2, 3, 4: begin
                month_byte = clean_bcd(1, 12);
                month_byte[7] = 1'($urandom_range(0, 1));
                return decode_beat({clean_bcd(0, 99), month_byte, clean_bcd(1, 31),
                                    8'($urandom_range(1, 7)), clean_bcd(0, 23),
                                    clean_bcd(0, 59), clean_bcd(0, 59)});
            end
            5, 6: return encode_beat($urandom_range(0, 59), $urandom_range(0, 59),
                                     $urandom_range(0, 23), $urandom_range(0, 6),
                                     $urandom_range(1, 31), $urandom_range(1, 12),
                                     $urandom_range(1970, 2169));
            7: return encode_beat($urandom_range(0, 59), $urandom_range(0, 59),
                                  $urandom_range(0, 23), $urandom_range(0, 6),
                                  $urandom_range(1, 31), $urandom_range(1, 12),
                                  $urandom_range(1990, 2110));
            default: return encode_beat($urandom_range(0, 63), $urandom_range(0, 63),
                                        $urandom_range(0, 31), $urandom_range(0, 7),
                                        $urandom_range(0, 31), $urandom_range(0, 15),
                                        $urandom_range(0, 4095));
        endcase
    endfunction

    // Offers one beat and returns once it has been accepted. Valid stays
    // high between back-to-back beats; a gap, when one is drawn, lowers it first.
    task automatic send_beat(t_in_beat b);
        int unsigned gap;
        if (idle_enabled && !quiet_tail && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 16);
            @(negedge i_clk);
            in_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.opcode         = b.opcode;
        in_ch.register_image = b.image;
        in_ch.seconds_in     = b.fields.seconds;
        in_ch.minutes_in     = b.fields.minutes;
        in_ch.hours_in       = b.fields.hours;
        in_ch.weekday_in     = b.fields.weekday;
        in_ch.day_in         = b.fields.day;
        in_ch.month_in       = b.fields.month;
        in_ch.year_in        = b.fields.year;
        in_ch.valid          = 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Withdraws valid and waits until every predicted result has arrived.
    // The watchdog bounds this wait.
    task automatic wait_for_drain();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (sb.waiting() != 0) @(posedge i_clk);
    endtask

    initial begin
        in_ch.valid          = 1'b0;
        in_ch.opcode         = 1'b0;
        in_ch.register_image = '0;
        in_ch.seconds_in     = '0;
        in_ch.minutes_in     = '0;
        in_ch.hours_in       = '0;
        in_ch.weekday_in     = '0;
        in_ch.day_in         = '0;
        in_ch.month_in       = '0;
        in_ch.year_in        = '0;

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Decode: empty and full images, ordinary dates, the century flag on
        // both sides of the 2070 split, digits above nine and every clamp.
        send_beat(decode_beat(56'h00_00_00_00_00_00_00));
        send_beat(decode_beat(56'hff_ff_ff_ff_ff_ff_ff));
        send_beat(decode_beat(56'h25_12_31_06_23_59_59));
        send_beat(decode_beat(56'h99_81_15_03_12_30_45));
        send_beat(decode_beat(56'h69_81_01_01_00_00_00));
        send_beat(decode_beat(56'h70_92_28_02_07_08_09));
        send_beat(decode_beat(56'ha0_13_32_f8_24_60_5a));
        send_beat(decode_beat(56'h00_00_00_07_00_00_00));
        send_beat(decode_beat(56'hfa_9f_3f_85_3f_ff_ff));
        send_beat(decode_beat(56'h09_6a_c9_40_d5_80_80));

        // Encode: zero and all-ones fields, the century edges 1999/2000 and
        // 2099/2100, the ends of the range, a year far outside it, and the
        // weekday that packs to eight.
        send_beat(encode_beat(0, 0, 0, 0, 0, 0, 0));
        send_beat(encode_beat(63, 63, 31, 7, 31, 15, 4095));
        send_beat(encode_beat(59, 59, 23, 6, 31, 12, 2025));
        send_beat(encode_beat(0, 0, 0, 0, 1, 1, 1970));
        send_beat(encode_beat(30, 30, 12, 3, 15, 6, 1999));
        send_beat(encode_beat(1, 2, 3, 4, 5, 7, 2000));
        send_beat(encode_beat(45, 10, 19, 5, 20, 10, 2099));
        send_beat(encode_beat(9, 19, 20, 1, 29, 2, 2100));
        send_beat(encode_beat(59, 59, 23, 6, 31, 12, 2169));
        send_beat(encode_beat(10, 9, 19, 5, 20, 10, 2170));
        send_beat(encode_beat(0, 40, 8, 2, 10, 11, 1234));

        for (int unsigned i = 0; i < RANDOM_BEATS; i++) begin
            if (i % 100 == 0) begin
                idle_enabled = ($urandom_range(0, 3) != 0);
            end
            if (i == RANDOM_BEATS - QUIET_TAIL) begin
                quiet_tail = 1'b1;
            end
            if (i == DRAIN_POINT) begin
                wait_for_drain();
            end
            send_beat(random_beat());
        end

        // Let the pipeline empty, then keep watching the output so that a
        // stray extra result would still be caught.
        wait_for_drain();
        repeat (8) @(posedge i_clk);

        if (sb.failures() == 0 && sb.waiting() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
